>>> hw/rtl/jkse_pkg.sv
// Shared types and constants for the JSON key string extractor.
`timescale 1ns / 1ps
`default_nettype none

package jkse_pkg;

   // Window and count sizing
   localparam int PATTERN_BYTES = 32;
   localparam int WIN_DEPTH     = PATTERN_BYTES - 1;
   localparam int SEEN_W        = $clog2(WIN_DEPTH + 1);
   localparam int PLEN_W        = $clog2(PATTERN_BYTES + 2);
   localparam int COUNT_BITS    = 16;

   // Key storage: four 64-bit words of eight characters each
   localparam int KEY_WORDS     = 4;
   localparam int KEY_SLOTS     = KEY_WORDS * 8;
   localparam int KEY_IDX_W     = $clog2(KEY_SLOTS);
   localparam int KEY_LEN_W     = 5;

   // Register port sizing
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;
   localparam int REG_IDX_W     = 3;
   localparam int CAP_RESET     = 64;

   // Character codes
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;

   // Register map indexes (byte address is 8 times the index)
   typedef enum logic [REG_IDX_W-1:0] {
      REG_KEY_LENGTH  = 3'd0,
      REG_KEY_CHARS_0 = 3'd1,
      REG_KEY_CHARS_1 = 3'd2,
      REG_KEY_CHARS_2 = 3'd3,
      REG_KEY_CHARS_3 = 3'd4,
      REG_CAPACITY    = 3'd5
   } reg_idx_type;

   // Parser phases
   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_WS1    = 3'd1,
      PH_WS2    = 3'd2,
      PH_VALUE  = 3'd3,
      PH_ESCAPE = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   // Final status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_INVALID   = 2'd2,
      ST_NO_ROOM   = 2'd3
   } status_type;

   // Result kinds
   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [KEY_LEN_W-1:0]                 key_length;
      logic [KEY_WORDS-1:0][CSR_DATA_W-1:0] key_words;
      logic [COUNT_BITS-1:0]                capacity;
   } cfg_type;

   // Window control from the parser to the matcher
   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctrl_type;

   // Match status from the matcher to the parser
   typedef struct packed {
      logic key_match;
      logic key_too_long;
   } win_stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/jkse_req_if.sv
// Input channel interface: one document byte or end-of-text marker per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface jkse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/jkse_rsp_if.sv
// Result channel interface: one value byte or final status per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface jkse_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  value_byte;
   logic [1:0]  status;
   logic [15:0] value_length;

   modport source (output valid, output result_kind, output value_byte, output status,
                   output value_length, input ready);
   modport sink   (input valid, input result_kind, input value_byte, input status,
                   input value_length, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/jkse_csr.sv
// APB-style configuration register file for the key extractor.
`timescale 1ns / 1ps
`default_nettype none

module jkse_csr import jkse_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type           cfg_ff, cfg_in;
   logic              wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign cfg     = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_KEY_LENGTH:  cfg_in.key_length   = pwdata[KEY_LEN_W-1:0];
            REG_KEY_CHARS_0: cfg_in.key_words[0] = pwdata;
            REG_KEY_CHARS_1: cfg_in.key_words[1] = pwdata;
            REG_KEY_CHARS_2: cfg_in.key_words[2] = pwdata;
            REG_KEY_CHARS_3: cfg_in.key_words[3] = pwdata;
            REG_CAPACITY:    cfg_in.capacity     = pwdata[COUNT_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_length <= '0;
         cfg_ff.key_words  <= '0;
         cfg_ff.capacity   <= COUNT_BITS'(CAP_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         REG_KEY_LENGTH:  prdata = CSR_DATA_W'(cfg_ff.key_length);
         REG_KEY_CHARS_0: prdata = cfg_ff.key_words[0];
         REG_KEY_CHARS_1: prdata = cfg_ff.key_words[1];
         REG_KEY_CHARS_2: prdata = cfg_ff.key_words[2];
         REG_KEY_CHARS_3: prdata = cfg_ff.key_words[3];
         REG_CAPACITY:    prdata = CSR_DATA_W'(cfg_ff.capacity);
         default:         prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/jkse_matcher.sv
// Sliding byte window and parallel compare against the quoted key pattern.
`timescale 1ns / 1ps
`default_nettype none

module jkse_matcher import jkse_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire win_ctrl_type ctrl,
   input  wire logic [7:0]   text_byte,
   output win_stat_type      stat
);

   logic [7:0]              recent_ff [WIN_DEPTH];
   logic [7:0]              recent_in [WIN_DEPTH];
   logic [SEEN_W-1:0]       seen_ff, seen_in, seen_next;
   logic [7:0]              key_bytes [KEY_SLOTS];
   logic [7:0]              want      [WIN_DEPTH];
   logic [WIN_DEPTH-1:0]    pos_ok;
   logic [KEY_SLOTS*8-1:0]  key_flat;
   logic [PLEN_W-1:0]       plen;

   assign key_flat = cfg.key_words;
   assign plen     = PLEN_W'(cfg.key_length) + PLEN_W'(2);

   // Unpack key characters, character 0 in the low byte of word 0
   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         key_bytes[i] = key_flat[i*8 +: 8];
      end
   end

   // Window as it looks once the current byte is shifted in (newest first)
   always_comb begin
      recent_in[0] = text_byte;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         recent_in[k] = recent_ff[k-1];
      end
   end

   assign seen_next = (seen_ff == SEEN_W'(WIN_DEPTH)) ? seen_ff : seen_ff + SEEN_W'(1);

   // Per-position compare; positions past the pattern length always pass
   always_comb begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
         if ((k == 0) || (PLEN_W'(k) == plen - PLEN_W'(1))) begin
            want[k] = CH_QUOTE;
         end else begin
            want[k] = key_bytes[KEY_IDX_W'(cfg.key_length) - KEY_IDX_W'(k)];
         end
         pos_ok[k] = (PLEN_W'(k) >= plen) || (recent_in[k] == want[k]);
      end
   end

   assign stat.key_too_long = (plen >= PLEN_W'(PATTERN_BYTES));
   assign stat.key_match    = (PLEN_W'(seen_next) >= plen) && (&pos_ok);

   // Fill counter
   always_comb begin
      seen_in = seen_ff;
      if (ctrl.clear) begin
         seen_in = '0;
      end else if (ctrl.shift) begin
         seen_in = seen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // Window bytes need no reset: the fill count masks stale entries
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         for (int k = 0; k < WIN_DEPTH; k++) begin
            recent_ff[k] <= recent_in[k];
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/jkse_parser.sv
// Phase sequencer, value decoder, emitted-byte counter and result register.
`timescale 1ns / 1ps
`default_nettype none

module jkse_parser import jkse_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            text_byte,
   input  wire logic                  end_of_text,
   input  wire win_stat_type          stat,
   output win_ctrl_type               ctrl,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_kind,
   output logic [7:0]                 rsp_byte,
   output status_type                 rsp_status,
   output logic [COUNT_BITS-1:0]      rsp_length
);

   phase_type               phase_ff, phase_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0]   rsp_length_ff, rsp_length_in;
   logic                    accept;
   logic                    load;
   logic                    is_space;
   logic                    no_room;
   logic [7:0]              esc_byte;

   // Output register frees its slot in the same cycle it is drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_space = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                     (text_byte == CH_LF) || (text_byte == CH_CR);
   assign no_room  = ({1'b0, count_ff} + (COUNT_BITS+1)'(1)) >= {1'b0, cfg.capacity};

   // Escape decode
   always_comb begin
      unique case (text_byte)
         CH_N:    esc_byte = CH_LF;
         CH_R:    esc_byte = CH_CR;
         CH_T:    esc_byte = CH_TAB;
         default: esc_byte = text_byte;
      endcase
   end

   // Next phase, counter and result
   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      ctrl.shift    = 1'b0;
      ctrl.clear    = 1'b0;
      load          = 1'b0;
      rsp_kind_in   = KIND_STATUS;
      rsp_byte_in   = '0;
      rsp_status_in = ST_OK;
      rsp_length_in = count_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (stat.key_too_long) begin
                  load          = 1'b1;
                  rsp_status_in = ST_INVALID;
                  phase_in      = end_of_text ? PH_SEARCH : PH_DONE;
               end else if (end_of_text) begin
                  load          = 1'b1;
                  rsp_status_in = ST_NOT_FOUND;
               end else begin
                  ctrl.shift = 1'b1;
                  if (stat.key_match) begin
                     phase_in = PH_WS1;
                  end
               end
            end
            PH_WS1, PH_WS2: begin
               if (end_of_text) begin
                  load          = 1'b1;
                  rsp_status_in = ST_INVALID;
                  phase_in      = PH_SEARCH;
               end else if (is_space) begin
                  phase_in = phase_ff;
               end else if ((phase_ff == PH_WS1) && (text_byte == CH_COLON)) begin
                  phase_in = PH_WS2;
               end else if ((phase_ff == PH_WS2) && (text_byte == CH_QUOTE)) begin
                  phase_in = PH_VALUE;
               end else begin
                  load          = 1'b1;
                  rsp_status_in = ST_INVALID;
                  phase_in      = PH_DONE;
               end
            end
            PH_VALUE: begin
               if (end_of_text) begin
                  load          = 1'b1;
                  rsp_status_in = ST_INVALID;
                  phase_in      = PH_SEARCH;
               end else if (text_byte == CH_QUOTE) begin
                  load          = 1'b1;
                  rsp_status_in = ST_OK;
                  phase_in      = PH_DONE;
               end else if (no_room) begin
                  load          = 1'b1;
                  rsp_status_in = ST_NO_ROOM;
                  phase_in      = PH_DONE;
               end else if (text_byte == CH_BACKSLASH) begin
                  phase_in = PH_ESCAPE;
               end else begin
                  load          = 1'b1;
                  rsp_kind_in   = KIND_VALUE;
                  rsp_byte_in   = text_byte;
                  rsp_length_in = '0;
                  count_in      = count_ff + COUNT_BITS'(1);
               end
            end
            PH_ESCAPE: begin
               if (end_of_text) begin
                  load          = 1'b1;
                  rsp_status_in = ST_INVALID;
                  phase_in      = PH_SEARCH;
               end else begin
                  load          = 1'b1;
                  rsp_kind_in   = KIND_VALUE;
                  rsp_byte_in   = esc_byte;
                  rsp_length_in = '0;
                  count_in      = count_ff + COUNT_BITS'(1);
                  phase_in      = PH_VALUE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         // End of text always rearms for the next document
         if (end_of_text) begin
            phase_in   = PH_SEARCH;
            count_in   = '0;
            ctrl.clear = 1'b1;
         end
      end
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_status_ff <= rsp_status_in;
         rsp_length_ff <= rsp_length_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result register not empty after reset");

   // The counter only advances together with a value byte loaded into the result register
   a_count_with_byte: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) && (count_ff != '0) |->
         rsp_valid_ff && (rsp_kind_ff == KIND_VALUE))
      else $error("emitted count moved without a value byte");

   // An escape is entered only from the value phase
   a_escape_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ESCAPE) && !$past(reset) |->
         ($past(phase_ff) == PH_VALUE) || ($past(phase_ff) == PH_ESCAPE))
      else $error("escape phase entered from outside the value");

   // After a status, ordinary bytes leave the block parked and silent
   a_done_parks: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_DONE) && !end_of_text |=>
         (phase_ff == PH_DONE) && !$rose(rsp_valid_ff))
      else $error("bytes after status were not ignored");

endmodule

`default_nettype wire

>>> hw/rtl/json_key_string_extractor_core.sv
// Top level of the JSON key string extractor: register file, window matcher and parser.
//
// Usage:
//   req_bus carries one document byte per transaction; end_of_text set marks the
//   terminating NUL and its text_byte is ignored. rsp_bus returns either one decoded
//   value byte (result_kind 0) or the single final status (result_kind 1) with the
//   number of value bytes emitted. Some bytes (search, whitespace, colon, opening quote,
//   backslash) produce no transaction.
//   Registers sit on the APB-style port at byte address 8*index, 64-bit data;
//   write them only while the block is idle.
//   Latency: a result is presented the cycle after its input byte is accepted.
//   Throughput: one input byte per cycle outside the stall described below, set by
//   the single registered step of the window compare and phase logic.
//   Reset: registers return to key_length 0, key characters 0, capacity 64; the
//   parser restarts in key search with an empty window and no pending result.
//   Stall: when the result register is full and rsp_bus.ready is low, req_bus.ready
//   drops; it is high again in the cycle the pending result is taken.
//   After a status, bytes are swallowed until end of text, which rearms the search.
`timescale 1ns / 1ps
`default_nettype none

module json_key_string_extractor_core import jkse_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   jkse_req_if.sink                   req_bus,
   jkse_rsp_if.source                 rsp_bus,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type               cfg;
   win_ctrl_type          win_ctrl;
   win_stat_type          win_stat;
   status_type            rsp_status;
   logic [COUNT_BITS-1:0] rsp_length;

   // Configuration registers
   jkse_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Key window
   jkse_matcher u_matcher (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ctrl      (win_ctrl),
      .text_byte (req_bus.text_byte),
      .stat      (win_stat)
   );

   // Parser and result register
   jkse_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .text_byte   (req_bus.text_byte),
      .end_of_text (req_bus.end_of_text),
      .stat        (win_stat),
      .ctrl        (win_ctrl),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_kind    (rsp_bus.result_kind),
      .rsp_byte    (rsp_bus.value_byte),
      .rsp_status  (rsp_status),
      .rsp_length  (rsp_length)
   );

   assign rsp_bus.status       = rsp_status;
   assign rsp_bus.value_length = rsp_length;

endmodule

`default_nettype wire
